// File: hw/rtl/rvr_pkg.sv
// ---------------------------------------------------------------------------
// rvr_pkg: shared constants for the Rodrigues vector rotation pipeline
// Fixed-point formats, pipeline depths and the sin/cos series tables.
// ---------------------------------------------------------------------------
package rvr_pkg;

   localparam int COORD_W = 32;
   localparam int ANGLE_W = 20;

   // Q2.30 one and quarter turn
   localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
   localparam logic [34:0] HALF_PI    = 35'd1686629713;
   localparam logic [34:0] HALF_PI_LO = 35'd843314856;   // floor(HALF_PI/2)
   // 8*HALF_PI + floor(HALF_PI/2): keeps the quadrant dividend positive
   localparam logic [34:0] ANGLE_BIAS = 35'd14336352560;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int QUO_STEPS  = 4;
   localparam int SC_STEPS   = 6;

   localparam int AX_LAT   = 4 + SQRT_STEPS + DIV_STEPS + 1;
   localparam int SC_LAT   = 4 + QUO_STEPS + 2 * SC_STEPS + 2;
   localparam int CB_LAT   = 4;
   localparam int PIPE_LAT = AX_LAT + CB_LAT;
   localparam int SC_DELAY = AX_LAT - SC_LAT;

   // cosine series, slot j: half divisor and ceil(2^40 / divisor)
   function automatic logic [6:0] cos_half(input int j);
      case (j)
         0:       cos_half = 7'd66;
         1:       cos_half = 7'd45;
         2:       cos_half = 7'd28;
         3:       cos_half = 7'd15;
         4:       cos_half = 7'd6;
         default: cos_half = 7'd1;
      endcase
   endfunction

   function automatic logic [39:0] cos_rcp(input int j);
      case (j)
         0:       cos_rcp = 40'd8329633544;
         1:       cos_rcp = 40'd12216795865;
         2:       cos_rcp = 40'd19634136211;
         3:       cos_rcp = 40'd36650387593;
         4:       cos_rcp = 40'd91625968982;
         default: cos_rcp = 40'd549755813888;
      endcase
   endfunction

   // sine series runs in slots 1..5
   function automatic logic [6:0] sin_half(input int j);
      case (j)
         1:       sin_half = 7'd55;
         2:       sin_half = 7'd36;
         3:       sin_half = 7'd21;
         4:       sin_half = 7'd10;
         default: sin_half = 7'd3;
      endcase
   endfunction

   function automatic logic [39:0] sin_rcp(input int j);
      case (j)
         1:       sin_rcp = 40'd9995560253;
         2:       sin_rcp = 40'd15270994831;
         3:       sin_rcp = 40'd26178848281;
         4:       sin_rcp = 40'd54975581389;
         default: sin_rcp = 40'd183251937963;
      endcase
   endfunction

endpackage

// File: hw/rtl/rvr_axis.sv
// ---------------------------------------------------------------------------
// rvr_axis: axis normalization pipeline
// Scales the axis, takes the integer square root of its squared length one
// bit per stage, then divides each component by it one quotient bit per stage.
// ---------------------------------------------------------------------------
module rvr_axis
   import rvr_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] axis_x,
   input  logic signed [31:0] axis_y,
   input  logic signed [31:0] axis_z,
   output logic signed [31:0] k_x,
   output logic signed [31:0] k_y,
   output logic signed [31:0] k_z,
   output logic               zero
);

   typedef struct packed {
      logic [2:0]       neg;
      logic             zero;
      logic [2:0][31:0] mag;
   } ax_tag_type;

   logic signed [31:0] a_w [3];
   logic [31:0]        mag_w [3];
   logic [31:0]        max_w;
   logic [31:0]        mag1_ff [3];
   logic [2:0]         neg1_ff;
   logic [31:0]        max1_ff;
   logic [4:0]         sh_w;
   ax_tag_type         tg2_ff;
   ax_tag_type         tg3_ff;
   ax_tag_type         tg4_ff;
   logic [63:0]        sq3_ff [3];
   logic [63:0]        sum4_ff;

   logic [63:0]        sr_rem_ff  [SQRT_STEPS];
   logic [31:0]        sr_root_ff [SQRT_STEPS];
   ax_tag_type         sr_tg_ff   [SQRT_STEPS];

   logic [63:0]        dv_rem_ff  [DIV_STEPS][3];
   logic [30:0]        dv_q_ff    [DIV_STEPS][3];
   logic [31:0]        dv_len_ff  [DIV_STEPS];
   logic [2:0]         dv_neg_ff  [DIV_STEPS];
   logic               dv_zero_ff [DIV_STEPS];

   logic signed [31:0] k_ff [3];
   logic               zero_ff;

   assign a_w[0] = axis_x;
   assign a_w[1] = axis_y;
   assign a_w[2] = axis_z;

   // stage 1: magnitudes and largest magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_w[i] = a_w[i][31] ? (~a_w[i] + 32'd1) : a_w[i];
      end
      max_w = mag_w[0];
      if (mag_w[1] > max_w) begin
         max_w = mag_w[1];
      end
      if (mag_w[2] > max_w) begin
         max_w = mag_w[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= mag_w;
         neg1_ff <= {a_w[2][31], a_w[1][31], a_w[0][31]};
         max1_ff <= max_w;
      end
   end

   // stage 2: common left shift that puts the largest into [2^30, 2^31]
   always_comb begin
      sh_w = '0;
      for (int i = 0; i < 31; i++) begin
         if (max1_ff[i]) begin
            sh_w = 5'(30 - i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            tg2_ff.mag[i] <= mag1_ff[i] << sh_w;
         end
         tg2_ff.neg  <= neg1_ff;
         tg2_ff.zero <= (max1_ff == '0);
      end
   end

   // stage 3: squares, stage 4: sum of squares
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq3_ff[i] <= 64'(tg2_ff.mag[i]) * 64'(tg2_ff.mag[i]);
         end
         tg3_ff  <= tg2_ff;
         sum4_ff <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         tg4_ff  <= tg3_ff;
      end
   end

   // square root, one root bit per stage, MSB first
   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      localparam int B = SQRT_STEPS - 1 - g;
      logic [63:0] rem_w;
      logic [31:0] root_w;
      ax_tag_type  tg_w;
      logic [65:0] trial_w;

      if (g == 0) begin : g_first
         assign rem_w  = sum4_ff;
         assign root_w = '0;
         assign tg_w   = tg4_ff;
      end else begin : g_next
         assign rem_w  = sr_rem_ff[g-1];
         assign root_w = sr_root_ff[g-1];
         assign tg_w   = sr_tg_ff[g-1];
      end

      // (root + 2^B)^2 - root^2
      assign trial_w = (66'(root_w) << (B + 1)) | (66'(1) << (2 * B));

      always_ff @(posedge clock) begin
         if (en) begin
            if (66'(rem_w) >= trial_w) begin
               sr_rem_ff[g]  <= rem_w - trial_w[63:0];
               sr_root_ff[g] <= root_w | (32'(1) << B);
            end else begin
               sr_rem_ff[g]  <= rem_w;
               sr_root_ff[g] <= root_w;
            end
            sr_tg_ff[g] <= tg_w;
         end
      end
   end

   // rounded division mag * 2^30 / len, one quotient bit per stage
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      localparam int B = DIV_STEPS - 1 - g;
      logic [63:0] rem_w [3];
      logic [30:0] q_w   [3];
      logic [31:0] len_w;
      logic [2:0]  neg_w;
      logic        zero_w;
      logic [63:0] dvs_w;

      if (g == 0) begin : g_first
         assign len_w  = sr_root_ff[SQRT_STEPS-1];
         assign neg_w  = sr_tg_ff[SQRT_STEPS-1].neg;
         assign zero_w = sr_tg_ff[SQRT_STEPS-1].zero;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_w[i] = {2'b00, sr_tg_ff[SQRT_STEPS-1].mag[i], 30'b0}
                              + 64'(len_w >> 1);
            assign q_w[i]   = '0;
         end
      end else begin : g_next
         assign len_w  = dv_len_ff[g-1];
         assign neg_w  = dv_neg_ff[g-1];
         assign zero_w = dv_zero_ff[g-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_w[i] = dv_rem_ff[g-1][i];
            assign q_w[i]   = dv_q_ff[g-1][i];
         end
      end

      assign dvs_w = 64'(len_w) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               if (rem_w[i] >= dvs_w) begin
                  dv_rem_ff[g][i] <= rem_w[i] - dvs_w;
                  dv_q_ff[g][i]   <= q_w[i] | (31'(1) << B);
               end else begin
                  dv_rem_ff[g][i] <= rem_w[i];
                  dv_q_ff[g][i]   <= q_w[i];
               end
            end
            dv_len_ff[g]  <= len_w;
            dv_neg_ff[g]  <= neg_w;
            dv_zero_ff[g] <= zero_w;
         end
      end
   end

   // restore signs
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_neg_ff[DIV_STEPS-1][i]) begin
               k_ff[i] <= -$signed({1'b0, dv_q_ff[DIV_STEPS-1][i]});
            end else begin
               k_ff[i] <= $signed({1'b0, dv_q_ff[DIV_STEPS-1][i]});
            end
         end
         zero_ff <= dv_zero_ff[DIV_STEPS-1];
      end
   end

   assign k_x  = k_ff[0];
   assign k_y  = k_ff[1];
   assign k_z  = k_ff[2];
   assign zero = zero_ff;

endmodule

// File: hw/rtl/rvr_sincos.sv
// ---------------------------------------------------------------------------
// rvr_sincos: pipelined sine and cosine in Q2.30
// Quadrant reduction by a 4-step divider, then nested Taylor series, one
// series term per two stages, sine and cosine side by side.
// ---------------------------------------------------------------------------
module rvr_sincos
   import rvr_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [19:0] angle,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [29:0] r2;
      logic [29:0] ra;
      logic        neg;
      logic [1:0]  quad;
   } sc_tag_type;

   logic signed [35:0] t_w;
   logic signed [35:0] x_w;
   logic [34:0]        x_ff;
   logic [34:0]        qr_ff [QUO_STEPS];
   logic [3:0]         qq_ff [QUO_STEPS];

   logic signed [31:0] r_w;
   logic [29:0]        ra6_ff;
   logic               neg6_ff;
   logic [1:0]         quad6_ff;
   logic [59:0]        r2p7_ff;
   logic [29:0]        ra7_ff;
   logic               neg7_ff;
   logic [1:0]         quad7_ff;
   sc_tag_type         tg8_ff;

   logic [60:0]        pac_ff [SC_STEPS];
   logic [71:0]        pbc_ff [SC_STEPS];
   logic [60:0]        pas_ff [1:SC_STEPS-1];
   logic [71:0]        pbs_ff [1:SC_STEPS-1];
   sc_tag_type         tga_ff [SC_STEPS];
   sc_tag_type         tgb_ff [SC_STEPS];

   logic [60:0]        ps21_ff;
   logic [30:0]        uc21_ff;
   sc_tag_type         tg21_ff;

   logic [30:0]        srm_w;
   logic signed [31:0] sr_w;
   logic signed [31:0] cr_w;
   logic signed [31:0] s_ff;
   logic signed [31:0] c_ff;

   // angle to Q.30 plus bias
   assign t_w = 36'(angle) <<< 14;
   assign x_w = t_w + $signed({1'b0, ANGLE_BIAS});

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_w[34:0];
      end
   end

   // quadrant count by restoring division
   for (genvar g = 0; g < QUO_STEPS; g++) begin : g_quo
      localparam int B = QUO_STEPS - 1 - g;
      logic [34:0] cur_w;
      logic [3:0]  q_w;
      logic [34:0] dvs_w;

      if (g == 0) begin : g_first
         assign cur_w = x_ff;
         assign q_w   = '0;
      end else begin : g_next
         assign cur_w = qr_ff[g-1];
         assign q_w   = qq_ff[g-1];
      end

      assign dvs_w = HALF_PI << B;

      always_ff @(posedge clock) begin
         if (en) begin
            if (cur_w >= dvs_w) begin
               qr_ff[g] <= cur_w - dvs_w;
               qq_ff[g] <= q_w | (4'(1) << B);
            end else begin
               qr_ff[g] <= cur_w;
               qq_ff[g] <= q_w;
            end
         end
      end
   end

   // residual angle, |r| <= pi/4
   assign r_w = $signed({1'b0, qr_ff[QUO_STEPS-1][30:0]})
                - $signed({1'b0, HALF_PI_LO[30:0]});

   always_ff @(posedge clock) begin
      if (en) begin
         ra6_ff   <= r_w[31] ? 30'(-r_w) : r_w[29:0];
         neg6_ff  <= r_w[31];
         quad6_ff <= qq_ff[QUO_STEPS-1][1:0];

         r2p7_ff  <= 60'(ra6_ff) * 60'(ra6_ff);
         ra7_ff   <= ra6_ff;
         neg7_ff  <= neg6_ff;
         quad7_ff <= quad6_ff;

         tg8_ff.r2   <= 30'((r2p7_ff + 60'd536870912) >> 30);
         tg8_ff.ra   <= ra7_ff;
         tg8_ff.neg  <= neg7_ff;
         tg8_ff.quad <= quad7_ff;
      end
   end

   // series slots: u = 1 - round(r2*u)/d, divide via reciprocal multiply
   for (genvar g = 0; g < SC_STEPS; g++) begin : g_slot
      sc_tag_type  tin_w;
      logic [30:0] uc_w;

      if (g == 0) begin : g_first
         assign tin_w = tg8_ff;
         assign uc_w  = ONE_Q30;
      end else begin : g_next
         assign tin_w = tgb_ff[g-1];
         assign uc_w  = ONE_Q30 - pbc_ff[g-1][70:40];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pac_ff[g] <= 61'(tin_w.r2) * 61'(uc_w);
            tga_ff[g] <= tin_w;
            pbc_ff[g] <= 72'(32'((pac_ff[g] + 61'd536870912) >> 30) + 32'(cos_half(g)))
                         * 72'(cos_rcp(g));
            tgb_ff[g] <= tga_ff[g];
         end
      end

      if (g >= 1) begin : g_sin
         logic [30:0] us_w;

         if (g == 1) begin : g_first
            assign us_w = ONE_Q30;
         end else begin : g_next
            assign us_w = ONE_Q30 - pbs_ff[g-1][70:40];
         end

         always_ff @(posedge clock) begin
            if (en) begin
               pas_ff[g] <= 61'(tin_w.r2) * 61'(us_w);
               pbs_ff[g] <= 72'(32'((pas_ff[g] + 61'd536870912) >> 30)
                                + 32'(sin_half(g))) * 72'(sin_rcp(g));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ps21_ff <= 61'(tgb_ff[SC_STEPS-1].ra)
                    * 61'(ONE_Q30 - pbs_ff[SC_STEPS-1][70:40]);
         uc21_ff <= ONE_Q30 - pbc_ff[SC_STEPS-1][70:40];
         tg21_ff <= tgb_ff[SC_STEPS-1];
      end
   end

   // final sine scale and quadrant fold
   assign srm_w = 31'((ps21_ff + 61'd536870912) >> 30);
   assign sr_w  = tg21_ff.neg ? -$signed({1'b0, srm_w}) : $signed({1'b0, srm_w});
   assign cr_w  = $signed({1'b0, uc21_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         case (tg21_ff.quad)
            QUAD_0: begin
               s_ff <= sr_w;
               c_ff <= cr_w;
            end
            QUAD_1: begin
               s_ff <= cr_w;
               c_ff <= -sr_w;
            end
            QUAD_2: begin
               s_ff <= -sr_w;
               c_ff <= -cr_w;
            end
            QUAD_3: begin
               s_ff <= -cr_w;
               c_ff <= sr_w;
            end
            default: begin
               s_ff <= sr_w;
               c_ff <= cr_w;
            end
         endcase
      end
   end

   assign sin_q = s_ff;
   assign cos_q = c_ff;

endmodule

// File: hw/rtl/rvr_combine.sv
// ---------------------------------------------------------------------------
// rvr_combine: Rodrigues combination
// Cross and dot products, the three scaled terms, sum and saturation.
// The last stage is the result register.
// ---------------------------------------------------------------------------
module rvr_combine
   import rvr_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] k_x,
   input  logic signed [31:0] k_y,
   input  logic signed [31:0] k_z,
   input  logic signed [31:0] v_x,
   input  logic signed [31:0] v_y,
   input  logic signed [31:0] v_z,
   input  logic signed [31:0] sin_q,
   input  logic signed [31:0] cos_q,
   input  logic               zero,
   output logic signed [31:0] rot_x,
   output logic signed [31:0] rot_y,
   output logic signed [31:0] rot_z,
   output logic               axis_zero
);

   // round half up, drop 30 fraction bits
   function automatic logic signed [71:0] rnd30(input logic signed [71:0] x);
      rnd30 = (x + 72'sd536870912) >>> 30;
   endfunction

   logic signed [31:0] k_w [3];
   logic signed [31:0] v_w [3];
   logic signed [32:0] e_w;

   logic signed [63:0] kv1_ff [3][3];
   logic signed [63:0] vc1_ff [3];
   logic signed [64:0] ke1_ff [3];
   logic signed [31:0] s1_ff;
   logic signed [31:0] v1_ff [3];
   logic               z1_ff;

   logic signed [34:0] cr2_ff [3];
   logic signed [35:0] d2_ff;
   logic signed [33:0] t1_2_ff [3];
   logic signed [34:0] ke2_ff [3];
   logic signed [31:0] s2_ff;
   logic signed [31:0] v2_ff [3];
   logic               z2_ff;
   logic signed [71:0] dot_w;

   logic signed [71:0] m2_ff [3];
   logic signed [71:0] m3_ff [3];
   logic signed [33:0] t1_3_ff [3];
   logic signed [31:0] v3_ff [3];
   logic               z3_ff;

   logic signed [71:0] sum_w [3];
   logic signed [31:0] rot_ff [3];
   logic               zero_ff;

   assign k_w[0] = k_x;
   assign k_w[1] = k_y;
   assign k_w[2] = k_z;
   assign v_w[0] = v_x;
   assign v_w[1] = v_y;
   assign v_w[2] = v_z;
   assign e_w    = 33'sd1073741824 - 33'(cos_q);

   // stage 1: products k*v, v*c and k*(1-c)
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               kv1_ff[i][j] <= 64'(k_w[i]) * 64'(v_w[j]);
            end
            vc1_ff[i] <= 64'(v_w[i]) * 64'(cos_q);
            ke1_ff[i] <= 65'(k_w[i]) * 65'(e_w);
            v1_ff[i]  <= v_w[i];
         end
         s1_ff <= sin_q;
         z1_ff <= zero;
      end
   end

   // stage 2: cross product, dot product, rounded terms
   assign dot_w = rnd30(72'(kv1_ff[0][0]) + 72'(kv1_ff[1][1]) + 72'(kv1_ff[2][2]));

   for (genvar i = 0; i < 3; i++) begin : g_cross
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      logic signed [71:0] cr_w;
      logic signed [71:0] t1_w;
      logic signed [71:0] ke_w;

      assign cr_w = rnd30(72'(kv1_ff[I1][I2]) - 72'(kv1_ff[I2][I1]));
      assign t1_w = rnd30(72'(vc1_ff[i]));
      assign ke_w = rnd30(72'(ke1_ff[i]));

      always_ff @(posedge clock) begin
         if (en) begin
            cr2_ff[i]  <= cr_w[34:0];
            t1_2_ff[i] <= t1_w[33:0];
            ke2_ff[i]  <= ke_w[34:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_ff <= dot_w[35:0];
         s2_ff <= s1_ff;
         v2_ff <= v1_ff;
         z2_ff <= z1_ff;
      end
   end

   // stage 3: sine and axis terms
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            m2_ff[i]   <= 72'(cr2_ff[i]) * 72'(s2_ff);
            m3_ff[i]   <= 72'(ke2_ff[i]) * 72'(d2_ff);
            t1_3_ff[i] <= t1_2_ff[i];
         end
         v3_ff <= v2_ff;
         z3_ff <= z2_ff;
      end
   end

   // stage 4: sum, saturate, zero-axis bypass
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_w[i] = 72'(t1_3_ff[i]) + rnd30(m2_ff[i]) + rnd30(m3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (z3_ff) begin
               rot_ff[i] <= v3_ff[i];
            end else if (sum_w[i] > 72'sd2147483647) begin
               rot_ff[i] <= 32'sh7FFF_FFFF;
            end else if (sum_w[i] < -72'sd2147483648) begin
               rot_ff[i] <= 32'sh8000_0000;
            end else begin
               rot_ff[i] <= sum_w[i][31:0];
            end
         end
         zero_ff <= z3_ff;
      end
   end

   assign rot_x     = rot_ff[0];
   assign rot_y     = rot_ff[1];
   assign rot_z     = rot_ff[2];
   assign axis_zero = zero_ff;

endmodule

// File: hw/rtl/rodrigues_vector_rotation.sv
// ---------------------------------------------------------------------------
// rodrigues_vector_rotation: streaming Rodrigues rotation, Q16.16 vectors
//
//   channel   dir   handshake              payload
//   req_*     in    req_valid / req_stall  vec_x/y/z, axis_x/y/z, angle
//   rsp_*     out   rsp_valid / rsp_stall  rot_x/y/z, axis_zero
//
// One request per clock unless a result is held under rsp_stall. The depth
// is set by the axis path: 4 scaling stages, a 32-stage square root, a
// 31-stage divider and a sign stage, then 4 combine stages. Sin/cos (22
// stages) runs beside it and is delayed to match.
// Reset clears only the valid line; payload registers are not reset.
// When a result waits under rsp_stall the whole pipe holds and req_stall
// rises in the same cycle; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module rodrigues_vector_rotation
   import rvr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [19:0] req_angle,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z,
   output logic               rsp_axis_zero
);

   logic                      en;
   logic [PIPE_LAT-1:0]       vld_ff;
   logic [PIPE_LAT-1:0]       vld_in;

   logic signed [31:0]        k_x, k_y, k_z;
   logic                      ax_zero;
   logic signed [31:0]        sin_q, cos_q;

   // vector rides alongside the axis path, sin/cos waits for it
   logic [3*COORD_W-1:0]      vd_ff [AX_LAT];
   logic [63:0]               sd_ff [SC_DELAY];

   // global advance: everything moves unless a finished result is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[PIPE_LAT-1];

   assign vld_in = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vd_ff[0] <= {req_vec_x, req_vec_y, req_vec_z};
         for (int i = 1; i < AX_LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
         sd_ff[0] <= {sin_q, cos_q};
         for (int i = 1; i < SC_DELAY; i++) begin
            sd_ff[i] <= sd_ff[i-1];
         end
      end
   end

   rvr_axis u_axis (
      .clock  (clock),
      .en     (en),
      .axis_x (req_axis_x),
      .axis_y (req_axis_y),
      .axis_z (req_axis_z),
      .k_x    (k_x),
      .k_y    (k_y),
      .k_z    (k_z),
      .zero   (ax_zero)
   );

   rvr_sincos u_sincos (
      .clock (clock),
      .en    (en),
      .angle (req_angle),
      .sin_q (sin_q),
      .cos_q (cos_q)
   );

   rvr_combine u_combine (
      .clock     (clock),
      .en        (en),
      .k_x       (k_x),
      .k_y       (k_y),
      .k_z       (k_z),
      .v_x       (vd_ff[AX_LAT-1][95:64]),
      .v_y       (vd_ff[AX_LAT-1][63:32]),
      .v_z       (vd_ff[AX_LAT-1][31:0]),
      .sin_q     (sd_ff[SC_DELAY-1][63:32]),
      .cos_q     (sd_ff[SC_DELAY-1][31:0]),
      .zero      (ax_zero),
      .rot_x     (rsp_rot_x),
      .rot_y     (rsp_rot_y),
      .rot_z     (rsp_rot_z),
      .axis_zero (rsp_axis_zero)
   );

endmodule

// File: hw/rtl/rvr_checker.sv
// ---------------------------------------------------------------------------
// rvr_checker: port-level checks for rodrigues_vector_rotation
// Result hold under stall, input stall cause, reset behavior.
// ---------------------------------------------------------------------------
module rvr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_rot_x,
   input logic [31:0] rsp_rot_y,
   input logic [31:0] rsp_rot_z,
   input logic        rsp_axis_zero
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_rot_x) && $stable(rsp_rot_y)
                                 && $stable(rsp_rot_z) && $stable(rsp_axis_zero))
      else $error("result changed while stalled");

   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rodrigues_vector_rotation rvr_checker u_rvr_checker (.*);
